// ===== rtl/core/lpht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants shared by the linear probing hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int KEY_W  = 32;
    localparam int FUNC_W = 2;
    localparam int MOD_W  = 7;
    localparam int SLOT_W = 6;
    localparam int DIV_CNT_W = $clog2(KEY_W);

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    localparam logic [MOD_W-1:0] MOD_RESET = 7'd64;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
    } t_in_word;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic load;      // take input word, start division
        logic div_step;  // one remainder bit
        logic rd;        // read slot at probe position
        logic commit;    // probe matched: record result (and store on insert)
        logic advance;   // probe missed: next slot
        logic out_load;  // move result into output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_last;
        logic match;
        logic probe_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/lpht_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: division, probe read/check loop and result hand-off.
// ----------------------------------------------------------------------------
module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [FUNC_W-1:0] i_func,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd,
    output logic              o_in_stall
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIV    = 5'b00010,
        ST_READ   = 5'b00100,
        ST_CHECK  = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_func == FUNC_INSERT || i_func == FUNC_SEARCH) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_stat.match) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_FINISH;
                end else if (i_stat.probe_last) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = ST_READ;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/lpht_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_dpath
// Modulus register, bit-serial remainder, slot store and output register.
// ----------------------------------------------------------------------------
module lpht_dpath
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  logic             i_cfg_we,
    input  logic [MOD_W-1:0] i_cfg_data,
    input  t_in_word         i_in_data,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output t_out_word        o_out_data
);

    localparam int IDX_W  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int MaxMod = (TABLE_SIZE < 127) ? TABLE_SIZE : 127;
    localparam logic [MOD_W-1:0] MOD_MAX = MOD_W'(MaxMod);

    logic [MOD_W-1:0]     r_modulus;
    logic [MOD_W-1:0]     act_mod;
    logic [FUNC_W-1:0]    r_func;
    logic [KEY_W-1:0]     r_key;
    logic [KEY_W-1:0]     r_shift;
    logic [DIV_CNT_W-1:0] r_bit;
    logic [MOD_W-1:0]     r_pos;      // remainder during division, probe position after
    logic [MOD_W-1:0]     r_cnt;      // probes left
    logic [TABLE_SIZE-1:0] r_occ;
    logic [KEY_W-1:0]     r_rd_key;
    logic                 r_rd_occ;
    logic                 r_hit;
    logic [SLOT_W-1:0]    r_slot;
    logic                 r_out_valid;
    t_out_word            r_out;
    logic [KEY_W-1:0]     mem_keys [TABLE_SIZE];

    logic [MOD_W:0]       trial;
    logic [MOD_W-1:0]     n_rem;
    logic [MOD_W-1:0]     n_pos;
    logic [IDX_W-1:0]     idx;

    always_comb begin
        if (r_modulus == '0) begin
            act_mod = MOD_W'(1);
        end else if (r_modulus > MOD_MAX) begin
            act_mod = MOD_MAX;
        end else begin
            act_mod = r_modulus;
        end
    end

    // restoring remainder step: partial remainder stays below the modulus
    assign trial = {r_pos, r_shift[KEY_W-1]};
    assign n_rem = (trial >= {1'b0, act_mod}) ? MOD_W'(trial - {1'b0, act_mod})
                                              : trial[MOD_W-1:0];

    assign n_pos = (r_pos + MOD_W'(1) == act_mod) ? '0 : r_pos + MOD_W'(1);
    assign idx   = IDX_W'(r_pos);

    assign o_stat.div_last   = (r_bit == '0);
    assign o_stat.probe_last = (r_cnt == MOD_W'(1));
    assign o_stat.match      = (r_func == FUNC_INSERT) ? !r_rd_occ
                                                       : (r_rd_occ && r_rd_key == r_key);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RESET;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.load && i_in_data.func == FUNC_CLEAR) begin
            r_occ <= '0;
        end else if (i_cmd.commit && r_func == FUNC_INSERT) begin
            r_occ[idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_func == FUNC_INSERT) begin
            mem_keys[idx] <= r_key;
        end
        if (i_cmd.rd) begin
            r_rd_key <= mem_keys[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_occ <= r_occ[idx];
        end
        if (i_cmd.load) begin
            r_func  <= i_in_data.func;
            r_key   <= i_in_data.key;
            r_shift <= i_in_data.key;
            r_bit   <= DIV_CNT_W'(KEY_W - 1);
            r_pos   <= '0;
            r_cnt   <= act_mod;
            r_hit   <= (i_in_data.func == FUNC_CLEAR);
            r_slot  <= '0;
        end else if (i_cmd.div_step) begin
            r_shift <= {r_shift[KEY_W-2:0], 1'b0};
            r_pos   <= n_rem;
            r_bit   <= r_bit - DIV_CNT_W'(1);
        end else if (i_cmd.advance) begin
            r_pos <= n_pos;
            r_cnt <= r_cnt - MOD_W'(1);
        end else if (i_cmd.commit) begin
            r_hit  <= 1'b1;
            r_slot <= SLOT_W'(r_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.hit  <= r_hit;
            r_out.slot <= r_slot;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/linear_probe_hash_table_unit.sv =====
`timescale 1ns / 1ps
// Sequence: clear and unused codes go straight to the result; insert/search run the
//   bit-serial remainder, then P probes (1..effective modulus), each a registered
//   slot memory read followed by a check, then load the result.
// Throughput: one word at a time; next word taken once the result sits in the output reg.
// Reset: synchronous active-low; modulus 64, all slots empty, no result pending.
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing key table, linear probing from key mod modulus.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [MOD_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    lpht_dpath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives clear, insert, search and spare-code words into the linear probing
// hash table unit through phases of modulus settings, and keeps a table of
// its own to check every result word for hit and slot.
// ----------------------------------------------------------------------------
module testbench;
    import lpht_pkg::*;

    localparam int SLOTS       = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int WDOG_LIMIT  = 4000;
    localparam int PHASE_OPS   = 155;

    // spare operation code: no effect on the table, answers hit 0
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [MOD_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             o_in_stall;
    t_in_word         in_data = '0;
    logic             o_out_valid;
    logic             out_stall = 1'b0;
    t_out_word        o_out_data;

    // shadow of the table
    logic [MOD_W-1:0] modulus = MOD_RESET;
    bit               used [SLOTS];
    logic [KEY_W-1:0] stored [SLOTS];

    t_in_word  op_queue [$];
    t_out_word answers_q [$];

    bit quiet = 1'b0;       // no idling on either side
    bit hold_req = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;

    linear_probe_hash_table_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned live_slots();
        if (modulus == 0)
            return 1;
        if (modulus > SLOTS)
            return SLOTS;
        return modulus;
    endfunction

    // apply one word to the shadow table and return the answer it gives
    function automatic t_out_word table_step(t_in_word w);
        t_out_word   res;
        int unsigned m;
        int unsigned pos;
        res = '0;
        m = live_slots();
        pos = w.key % m;
        case (w.func)
            FUNC_CLEAR: begin
                foreach (used[i]) used[i] = 1'b0;
                res.hit = 1'b1;
            end
            FUNC_INSERT: begin
                for (int p = 0; p < m; p++) begin
                    if (!used[pos]) begin
                        used[pos] = 1'b1;
                        stored[pos] = w.key;
                        res.hit = 1'b1;
                        res.slot = pos[SLOT_W-1:0];
                        break;
                    end
                    pos = (pos + 1) % m;
                end
            end
            FUNC_SEARCH: begin
                for (int p = 0; p < m; p++) begin
                    if (used[pos] && stored[pos] == w.key) begin
                        res.hit = 1'b1;
                        res.slot = pos[SLOT_W-1:0];
                        break;
                    end
                    pos = (pos + 1) % m;
                end
            end
            default: res = '0;
        endcase
        return res;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && !o_in_stall)
                answers_q.push_back(table_step(in_data));
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (op_queue.size() != 0) begin
                    in_data  <= op_queue.pop_front();
                    in_valid <= 1'b1;
                    gap_left <= (!quiet && $urandom_range(0, 3) == 0) ?
                                $urandom_range(1, 4) : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (o_out_valid && !out_stall) begin
            if (answers_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word hit=%0b slot=%0d",
                             o_out_data.hit, o_out_data.slot);
            end else begin
                exp_w = answers_q.pop_front();
                if (o_out_data.hit !== exp_w.hit || o_out_data.slot !== exp_w.slot) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: expected hit=%0b slot=%0d, got hit=%0b slot=%0d",
                                 $realtime, exp_w.hit, exp_w.slot,
                                 o_out_data.hit, o_out_data.slot);
                end
            end
        end
        if (hold_req) begin
            hold_req = 1'b0;
            out_stall <= 1'b1;
            stall_left <= HOLD_CYCLES;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("timeout: no progress for %0d cycles", WDOG_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_op(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k);
        t_in_word w;
        w.func = f;
        w.key = k;
        op_queue.push_back(w);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (op_queue.size() != 0 || in_valid || answers_q.size() != 0);
    endtask

    task automatic write_modulus(logic [MOD_W-1:0] v);
        wait_idle();
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk);
        while (!(cfg_valid && o_cfg_ready));
        modulus = v;
        cfg_valid <= 1'b0;
    endtask

    // mostly inserts and searches over a small key set so that searches hit
    // and probe chains grow; the rest is random keys, clears and the spare code
    task automatic random_phase(logic [MOD_W-1:0] m_val, bit pressure);
        logic [KEY_W-1:0] pool [8];
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] base;
        int unsigned      m;
        int               r;
        write_modulus(m_val);
        m = live_slots();
        base = $urandom;
        foreach (pool[i])
            pool[i] = ($urandom_range(0, 1) == 0) ? $urandom : base + i * m;
        for (int n = 0; n < PHASE_OPS; n++) begin
            r = $urandom_range(0, 9);
            if (r < 6)
                k = pool[$urandom_range(0, 7)];
            else if (r < 8)
                k = $urandom;
            else
                k = base + $urandom_range(0, 3) * m + $urandom_range(0, 1);
            r = $urandom_range(0, 99);
            if (r == 0)
                push_op(FUNC_CLEAR, k);
            else if (r == 1)
                push_op(FUNC_UNUSED, k);
            else if (r < 60)
                push_op(FUNC_INSERT, k);
            else
                push_op(FUNC_SEARCH, k);
        end
        if (pressure)
            hold_req = 1'b1;
    endtask

    initial begin
        logic [MOD_W-1:0] phase_mods [12];
        phase_mods = '{7'd64, 7'd1, 7'd2, 7'd3, 7'd0, 7'd16, 7'd33, 7'd127,
                       7'd63, 7'd5, 7'd100, 7'd64};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset modulus: wrap-around, duplicates, unused code
        push_op(FUNC_SEARCH, 32'd0);
        push_op(FUNC_INSERT, 32'd0);
        push_op(FUNC_INSERT, 32'hFFFF_FFFF);
        push_op(FUNC_INSERT, 32'd64);
        push_op(FUNC_INSERT, 32'd64);
        push_op(FUNC_SEARCH, 32'd64);
        push_op(FUNC_SEARCH, 32'hFFFF_FFFF);
        push_op(FUNC_INSERT, 32'd127);
        push_op(FUNC_SEARCH, 32'd128);
        push_op(FUNC_UNUSED, 32'hFFFF_FFFF);
        push_op(FUNC_SEARCH, 32'd0);
        push_op(FUNC_INSERT, 32'd50);
        // shrink with keys held: slot 50 drops out of reach
        write_modulus(7'd16);
        push_op(FUNC_SEARCH, 32'd50);
        push_op(FUNC_SEARCH, 32'd64);
        push_op(FUNC_CLEAR, 32'd0);
        push_op(FUNC_SEARCH, 32'd0);
        // zero modulus behaves as one slot: full table on the second insert
        write_modulus(7'd0);
        push_op(FUNC_INSERT, 32'd12345);
        push_op(FUNC_INSERT, 32'd0);
        push_op(FUNC_SEARCH, 32'd12345);
        push_op(FUNC_SEARCH, 32'd0);
        push_op(FUNC_CLEAR, 32'd0);
        // above table size behaves as the full table
        write_modulus(7'd127);
        push_op(FUNC_INSERT, 32'h8000_003F);
        push_op(FUNC_SEARCH, 32'h8000_003F);
        push_op(FUNC_UNUSED, 32'd0);
        push_op(FUNC_CLEAR, 32'd0);

        foreach (phase_mods[i]) begin
            if (i == $size(phase_mods) - 1) begin
                wait_idle();
                quiet = 1'b1;
            end
            random_phase(phase_mods[i], i == 3);
        end

        wait_idle();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
